// File: rtl/gcs_pkg.sv
// Package for the grayscale contrast stretch block: item types, command codes
// and fixed widths. No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package gcs_pkg;

    localparam int PIX_W           = 8;
    localparam int NUM_W           = 2 * PIX_W;
    localparam int QUOT_BITS       = PIX_W;
    localparam int GCS_QUEUE_DEPTH = 2;

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_STRETCH = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [PIX_W-1:0] pixel_in;
        logic             last_in;
    } gcs_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             flat_range;
        logic             last_out;
    } gcs_out_t;

    // One classified stretch item on its way from the front end to the back end.
    typedef struct packed {
        logic             bypass;   // result already known, no division needed
        logic [PIX_W-1:0] value;    // result pixel when bypass is set
        logic             flat;
        logic             last;
        logic [NUM_W-1:0] num;      // 255 * (pixel - min)
        logic [PIX_W-1:0] den;      // max - min
    } gcs_job_t;

endpackage

// File: rtl/gcs_front.sv
// Front end of the contrast stretch block: accepts items, tracks the pixel
// range and turns stretch items into divider jobs. Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_front
    import gcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  gcs_in_t  in_item,
    input  logic     q_full,
    output logic     full,
    output logic     job_push,
    output gcs_job_t job
);

    logic [PIX_W-1:0] low_level_reg;
    logic [PIX_W-1:0] low_level_next;
    logic [PIX_W-1:0] high_level_reg;
    logic [PIX_W-1:0] high_level_next;
    logic             accept;
    logic [PIX_W-1:0] diff;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        low_level_next  = low_level_reg;
        high_level_next = high_level_reg;
        job_push        = 1'b0;
        if (accept)
        begin
            case (in_item.cmd)
                CMD_CLEAR:
                begin
                    low_level_next  = FULL_SCALE;
                    high_level_next = '0;
                end
                CMD_MEASURE:
                begin
                    if (in_item.pixel_in > high_level_reg)
                        high_level_next = in_item.pixel_in;
                    if (in_item.pixel_in < low_level_reg)
                        low_level_next = in_item.pixel_in;
                end
                CMD_STRETCH:
                    job_push = 1'b1;
                default:
                    job_push = 1'b0;
            endcase
        end
    end

    // Classify the stretch item against the range as it stands now.
    assign diff = in_item.pixel_in - low_level_reg;

    always_comb
    begin
        job.flat   = (high_level_reg <= low_level_reg);
        job.last   = in_item.last_in;
        job.num    = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
        job.den    = high_level_reg - low_level_reg;
        job.bypass = 1'b1;
        job.value  = '0;
        if (!job.flat)
        begin
            if (in_item.pixel_in >= high_level_reg)
                job.value = FULL_SCALE;
            else if (in_item.pixel_in > low_level_reg)
                job.bypass = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= FULL_SCALE;
            high_level_reg <= '0;
        end
        else
        begin
            low_level_reg  <= low_level_next;
            high_level_reg <= high_level_next;
        end
    end

endmodule

// File: rtl/gcs_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on gcs_pkg for the job type.
`timescale 1ns / 1ps

module gcs_queue
    import gcs_pkg::*;
#(
    parameter int DEPTH = GCS_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  gcs_job_t wr_job,
    input  logic     rd,
    output gcs_job_t rd_job,
    output logic     q_full,
    output logic     q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcs_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(wr && q_full))
        else $error("gcs_queue: write while full");

    // The fill count follows the pointers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("gcs_queue: empty queue with unequal pointers");

endmodule

// File: rtl/gcs_back.sv
// Back end of the contrast stretch block: serial restoring divider and the
// result register. Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_back
    import gcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gcs_job_t job,
    input  logic     q_empty,
    output logic     q_rd,
    output gcs_out_t out_item,
    output logic     empty,
    input  logic     pop
);

    localparam int STEP_W = $clog2(QUOT_BITS + 1);

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    state_t           state_reg;
    logic             res_valid_reg;
    gcs_out_t         res_reg;
    logic [PIX_W-1:0] rem_reg;
    logic [PIX_W-1:0] quo_reg;    // dividend low bits, then quotient bits
    logic [PIX_W-1:0] den_reg;
    logic             last_reg;
    logic [STEP_W-1:0] step_reg;
    logic             slot_free;
    logic             res_load;
    logic [PIX_W:0]   trial;
    logic [PIX_W:0]   trial_sub;
    logic             take;

    assign slot_free = !res_valid_reg || pop;
    assign empty     = !res_valid_reg;
    assign out_item  = res_reg;

    // A bypass job needs the result slot now; a division job only the divider.
    assign q_rd = (state_reg == ST_IDLE) && !q_empty && (!job.bypass || slot_free);

    // The result register takes a new item from a bypass job or a finished division.
    assign res_load = (q_rd && job.bypass)
                   || ((state_reg == ST_DIV) && (step_reg == '0) && slot_free);

    assign trial     = {rem_reg, quo_reg[PIX_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign take      = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            res_valid_reg <= res_load || (res_valid_reg && !pop);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_rd)
                    begin
                        if (job.bypass)
                        begin
                            res_reg.pixel_out  <= job.value;
                            res_reg.flat_range <= job.flat;
                            res_reg.last_out   <= job.last;
                        end
                        else
                        begin
                            rem_reg   <= job.num[NUM_W-1:PIX_W];
                            quo_reg   <= job.num[PIX_W-1:0];
                            den_reg   <= job.den;
                            last_reg  <= job.last;
                            step_reg  <= STEP_W'(QUOT_BITS);
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (step_reg != '0)
                    begin
                        rem_reg  <= take ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
                        quo_reg  <= {quo_reg[PIX_W-2:0], take};
                        step_reg <= step_reg - 1'b1;
                    end
                    else if (slot_free)
                    begin
                        res_reg.pixel_out  <= quo_reg;
                        res_reg.flat_range <= 1'b0;
                        res_reg.last_out   <= last_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // The partial remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("gcs_back: remainder not below divisor");

    // A flat range always gives a zero pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.flat_range) |-> (res_reg.pixel_out == '0))
        else $error("gcs_back: flat range with nonzero pixel");

endmodule

// File: rtl/grayscale_contrast_stretch.sv
// Top level of the min-max grayscale contrast stretch block.
// Depends on gcs_pkg, gcs_front, gcs_queue and gcs_back.
//
//   Channel   Handshake     Payload    Direction
//   input     push / full   in_item    into the block
//   result    empty / pop   out_item   out of the block
//
// Clear and measure items are handled in the front end and give no result.
// A stretch item whose answer is known without division (flat range, pixel at
// or below the minimum, at or above the maximum) is written straight into the
// result register from the head of the queue once the divider is idle and the
// result register is free. Any other stretch item is loaded into the serial
// restoring divider, goes through eight quotient steps, and is then written to
// the result register. The divider sets the sustained rate for such items.
// Reset is asynchronous and active low; the tracked range comes out of reset
// empty (minimum 255, maximum 0) and the queue and result register empty.
// A stalled result does not stop the front end: items are taken until the
// job queue fills, and the divider may finish one more item behind the result.
`timescale 1ns / 1ps

module grayscale_contrast_stretch
    import gcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = GCS_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  gcs_in_t  in_item,
    output logic     empty,
    input  logic     pop,
    output gcs_out_t out_item
);

    logic     job_push;
    gcs_job_t job_in;
    gcs_job_t job_head;
    logic     q_full;
    logic     q_empty;
    logic     q_rd;

    // The front end keeps the tracked minimum and maximum and classifies each
    // stretch item into either a ready answer or a division job.
    gcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job      (job_in)
    );

    // The queue decouples the front end from the slow divider.
    gcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_job  (job_in),
        .rd      (q_rd),
        .rd_job  (job_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back end divides 255 * (pixel - min) by (max - min), one quotient
    // bit per cycle, and holds the result until it is popped.
    gcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_head),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
